// File: hdl/cbpe_pkg.sv
package cbpe_pkg;

   // Field widths and fixed-point format
   localparam int COUNT_W   = 7;
   localparam int FRAC_BITS = 16;
   localparam logic [31:0] ONE_FIXED = 32'h0001_0000;

   // Command codes
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_SEGMENT = 2'd1;
   localparam logic [1:0] CMD_INDEX   = 2'd2;

   // Result kinds carried down the pipeline
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_CURVE = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [7:0]  point_index;
      logic signed [31:0] param_t;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
   } cbpe_req_type;

   typedef struct packed {
      logic signed [31:0] curve_x;
      logic signed [31:0] curve_y;
      logic               empty_error;
   } cbpe_rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } cbpe_vec_type;

   // One full path point as written
   typedef struct packed {
      cbpe_vec_type pos;
      cbpe_vec_type in_h;
      cbpe_vec_type out_h;
   } cbpe_point_type;

   // Position plus one handle, as held by each store
   typedef struct packed {
      cbpe_vec_type pos;
      cbpe_vec_type hnd;
   } cbpe_pair_type;

   // Signed 16.16 product, shifted right by the fraction width, wrapped to 32 bits
   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] prod;
      prod = $signed(a) * $signed(b);
      return prod[FRAC_BITS+31:FRAC_BITS];
   endfunction

   // Product with the fixed constant 3.0, which reduces to 3 * x
   function automatic logic [31:0] times3(input logic [31:0] x);
      return x + {x[30:0], 1'b0};
   endfunction

endpackage

// File: hdl/cbpe_point_store.sv
module cbpe_point_store #(
   parameter int MAX_POINTS = 64
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0]  wr_addr,
   input  cbpe_pkg::cbpe_point_type       wr_point,
   input  logic                           rd_en,
   input  logic [$clog2(MAX_POINTS)-1:0]  rd_addr_a,
   input  logic [$clog2(MAX_POINTS)-1:0]  rd_addr_b,
   output cbpe_pkg::cbpe_pair_type        rd_a,
   output cbpe_pkg::cbpe_pair_type        rd_b
);
   import cbpe_pkg::*;

   // Store A keeps position and out handle, store B position and in handle,
   // so a segment reads its start from A and its end from B in the same cycle.
   cbpe_pair_type mem_a [MAX_POINTS];
   cbpe_pair_type mem_b [MAX_POINTS];
   cbpe_pair_type rd_a_ff;
   cbpe_pair_type rd_b_ff;

   // Write both stores at the same entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= '{pos: wr_point.pos, hnd: wr_point.out_h};
         mem_b[wr_addr] <= '{pos: wr_point.pos, hnd: wr_point.in_h};
      end
   end

   // Read and hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr_a];
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// File: hdl/cubic_bezier_path_evaluator_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | cbpe_req_type (command, index, t, point)
// rsp     | out       | rsp_valid/rsp_stall  | cbpe_rsp_type (curve x, y, empty flag)
// csr     | in        | csr_valid/csr_ready  | point_count, 7 bits
//
// One item is taken per cycle while req_stall is low; an evaluation result reaches rsp
// through the store read, three multiplier stages and two adder stages.
// Writes take effect at acceptance and give no result.
// Synchronous reset clears point_count and all pipeline valids; stores are not cleared.
// rsp_stall backs up the pipeline; req_stall rises only when every stage is full.
module cubic_bezier_path_evaluator_top #(
   parameter int MAX_POINTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cbpe_pkg::cbpe_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cbpe_pkg::cbpe_rsp_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [6:0]             csr_wdata
);
   import cbpe_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] t;
      logic [31:0] u;
   } s1_type;

   typedef struct packed {
      logic [1:0]   kind;
      cbpe_vec_type p0;
      cbpe_vec_type p1;
      cbpe_vec_type p2;
      cbpe_vec_type p3;
      logic [31:0]  t;
      logic [31:0]  u;
      logic [31:0]  u2;
      logic [31:0]  t2;
   } s2_type;

   typedef struct packed {
      logic [1:0]   kind;
      cbpe_vec_type p0;
      cbpe_vec_type p3;
      cbpe_vec_type m1;
      cbpe_vec_type m2;
      logic [31:0]  t;
      logic [31:0]  t2;
      logic [31:0]  u3;
      logic [31:0]  t3;
   } s3_type;

   typedef struct packed {
      logic [1:0]   kind;
      cbpe_vec_type p0;
      cbpe_vec_type a;
      cbpe_vec_type d;
      cbpe_vec_type b1;
      cbpe_vec_type c1;
   } s4_type;

   typedef struct packed {
      logic [1:0]   kind;
      cbpe_vec_type p0;
      cbpe_vec_type ad;
      cbpe_vec_type b3;
      cbpe_vec_type c3;
   } s5_type;

   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic [COUNT_W-1:0] eff_count;
   logic [4:0]         stage_vld_ff, stage_vld_in;
   logic [4:0]         stage_ld;
   logic               out_ld;
   logic               rsp_valid_ff, rsp_valid_in;
   cbpe_rsp_type       rsp_item_ff, rsp_item_in;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;

   logic               accept;
   logic               accept_eval;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   cbpe_point_type     wr_point;
   logic [AW-1:0]      rd_addr_a;
   logic [AW-1:0]      rd_addr_b;
   cbpe_pair_type      rd_a;
   cbpe_pair_type      rd_b;

   logic [COUNT_W-1:0] seg_idx;
   logic [31:0]        seg_t;
   logic               first_case;
   logic               last_case;

   // Configuration register
   assign csr_ready = 1'b1;
   assign point_count_in = (csr_valid && csr_ready) ? csr_wdata : point_count_ff;

   // Clamp the count to the store depth
   always_comb begin
      if (int'(point_count_ff) >= MAX_POINTS) begin
         eff_count = COUNT_W'(MAX_POINTS);
      end else begin
         eff_count = point_count_ff;
      end
   end

   // Stage load chain, from the output back to the input
   always_comb begin
      out_ld = !rsp_valid_ff || !rsp_stall;
      stage_ld[4] = !stage_vld_ff[4] || out_ld;
      for (int k = 3; k >= 0; k--) begin
         stage_ld[k] = !stage_vld_ff[k] || stage_ld[k+1];
      end
   end

   assign req_stall   = !stage_ld[0];
   assign accept      = req_valid && !req_stall;
   assign accept_eval = accept && (req_item.cmd == CMD_SEGMENT || req_item.cmd == CMD_INDEX);

   // Point write: ignore indexes outside the store
   assign wr_en = accept && (req_item.cmd == CMD_WRITE) && !req_item.point_index[7]
                  && (int'(req_item.point_index[6:0]) < MAX_POINTS);
   assign wr_addr = AW'(req_item.point_index[6:0]);
   assign wr_point = '{pos:   '{x: req_item.pos_x, y: req_item.pos_y},
                       in_h:  '{x: req_item.in_x,  y: req_item.in_y},
                       out_h: '{x: req_item.out_x, y: req_item.out_y}};

   // Resolve segment index and t, clamping both command forms
   always_comb begin
      if (req_item.cmd == CMD_INDEX) begin
         first_case = 1'b0;
         if (req_item.param_t[31]) begin
            seg_idx = '0;
            seg_t   = '0;
         end else if (req_item.param_t[30:16] >= 15'(eff_count)) begin
            seg_idx = eff_count;
            seg_t   = '0;
         end else begin
            seg_idx = req_item.param_t[22:16];
            seg_t   = {16'd0, req_item.param_t[15:0]};
         end
      end else begin
         first_case = req_item.point_index[7];
         seg_idx    = req_item.point_index[6:0];
         seg_t      = req_item.param_t;
      end
      last_case = !first_case && (({1'b0, seg_idx} + 8'd1) >= {1'b0, eff_count});

      s1_in.t = seg_t;
      s1_in.u = ONE_FIXED - seg_t;
      priority if (eff_count == '0) begin
         s1_in.kind = KIND_EMPTY;
      end else if (first_case || last_case) begin
         s1_in.kind = KIND_POINT;
      end else begin
         s1_in.kind = KIND_CURVE;
      end

      priority if (first_case) begin
         rd_addr_a = '0;
      end else if (last_case) begin
         rd_addr_a = AW'(eff_count - COUNT_W'(1));
      end else begin
         rd_addr_a = AW'(seg_idx);
      end
      rd_addr_b = AW'(seg_idx + COUNT_W'(1));
   end

   cbpe_point_store #(
      .MAX_POINTS (MAX_POINTS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_point  (wr_point),
      .rd_en     (accept_eval),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   // Control points and squares
   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.p0   = rd_a.pos;
      s2_in.p3   = rd_b.pos;
      s2_in.p1.x = rd_a.pos.x + rd_a.hnd.x;
      s2_in.p1.y = rd_a.pos.y + rd_a.hnd.y;
      s2_in.p2.x = rd_b.pos.x + rd_b.hnd.x;
      s2_in.p2.y = rd_b.pos.y + rd_b.hnd.y;
      s2_in.t    = s1_ff.t;
      s2_in.u    = s1_ff.u;
      s2_in.u2   = fx_mul(s1_ff.u, s1_ff.u);
      s2_in.t2   = fx_mul(s1_ff.t, s1_ff.t);
   end

   // Cubes and first partial products of the inner terms
   always_comb begin
      s3_in.kind = s2_ff.kind;
      s3_in.p0   = s2_ff.p0;
      s3_in.p3   = s2_ff.p3;
      s3_in.t    = s2_ff.t;
      s3_in.t2   = s2_ff.t2;
      s3_in.u3   = fx_mul(s2_ff.u2, s2_ff.u);
      s3_in.t3   = fx_mul(s2_ff.t2, s2_ff.t);
      s3_in.m1.x = fx_mul(s2_ff.p1.x, s2_ff.u2);
      s3_in.m1.y = fx_mul(s2_ff.p1.y, s2_ff.u2);
      s3_in.m2.x = fx_mul(s2_ff.p2.x, s2_ff.u);
      s3_in.m2.y = fx_mul(s2_ff.p2.y, s2_ff.u);
   end

   // Four weighted terms, before the factor of three
   always_comb begin
      s4_in.kind = s3_ff.kind;
      s4_in.p0   = s3_ff.p0;
      s4_in.a.x  = fx_mul(s3_ff.p0.x, s3_ff.u3);
      s4_in.a.y  = fx_mul(s3_ff.p0.y, s3_ff.u3);
      s4_in.d.x  = fx_mul(s3_ff.p3.x, s3_ff.t3);
      s4_in.d.y  = fx_mul(s3_ff.p3.y, s3_ff.t3);
      s4_in.b1.x = fx_mul(s3_ff.m1.x, s3_ff.t);
      s4_in.b1.y = fx_mul(s3_ff.m1.y, s3_ff.t);
      s4_in.c1.x = fx_mul(s3_ff.m2.x, s3_ff.t2);
      s4_in.c1.y = fx_mul(s3_ff.m2.y, s3_ff.t2);
   end

   // Scale the inner terms and pair the outer ones
   always_comb begin
      s5_in.kind = s4_ff.kind;
      s5_in.p0   = s4_ff.p0;
      s5_in.ad.x = s4_ff.a.x + s4_ff.d.x;
      s5_in.ad.y = s4_ff.a.y + s4_ff.d.y;
      s5_in.b3.x = times3(s4_ff.b1.x);
      s5_in.b3.y = times3(s4_ff.b1.y);
      s5_in.c3.x = times3(s4_ff.c1.x);
      s5_in.c3.y = times3(s4_ff.c1.y);
   end

   // Final sum and result selection
   always_comb begin
      unique case (s5_ff.kind)
         KIND_EMPTY: begin
            rsp_item_in = '{curve_x: '0, curve_y: '0, empty_error: 1'b1};
         end
         KIND_POINT: begin
            rsp_item_in = '{curve_x: s5_ff.p0.x, curve_y: s5_ff.p0.y, empty_error: 1'b0};
         end
         KIND_CURVE: begin
            rsp_item_in = '{curve_x: s5_ff.ad.x + s5_ff.b3.x + s5_ff.c3.x,
                            curve_y: s5_ff.ad.y + s5_ff.b3.y + s5_ff.c3.y,
                            empty_error: 1'b0};
         end
         default: begin
            rsp_item_in = '{curve_x: '0, curve_y: '0, empty_error: 1'b0};
         end
      endcase
   end

   // Advance valids where a stage loads, hold otherwise
   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (stage_ld[0]) begin
         stage_vld_in[0] = accept_eval;
      end
      for (int k = 1; k < 5; k++) begin
         if (stage_ld[k]) begin
            stage_vld_in[k] = stage_vld_ff[k-1];
         end
      end
      rsp_valid_in = out_ld ? stage_vld_ff[4] : rsp_valid_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         stage_vld_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         point_count_ff <= point_count_in;
         stage_vld_ff   <= stage_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         s1_ff <= s1_in;
      end
      if (stage_ld[1]) begin
         s2_ff <= s2_in;
      end
      if (stage_ld[2]) begin
         s3_ff <= s3_in;
      end
      if (stage_ld[3]) begin
         s4_ff <= s4_in;
      end
      if (stage_ld[4]) begin
         s5_ff <= s5_in;
      end
      if (out_ld) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && (&stage_vld_ff)))
      else $error("input stalled while the pipeline has a free stage");

   a_write_no_slot: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd != CMD_SEGMENT && req_item.cmd != CMD_INDEX)
      |=> !stage_vld_ff[0])
      else $error("non-evaluation item entered the pipeline");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.empty_error)
      |-> (rsp_item_ff.curve_x == '0 && rsp_item_ff.curve_y == '0))
      else $error("empty-path result carries a nonzero point");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   import cbpe_pkg::*;

   localparam int          PATH_DEPTH = 64;
   localparam logic [31:0] THREE_Q16  = 32'd196608;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int          PHASE_ITEMS = 183;

   // One directed row: either a point_count load or a request item
   typedef struct {
      bit           is_cfg;
      logic [6:0]   cfg_value;
      cbpe_req_type req;
      bit           typed;
      cbpe_rsp_type known;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cbpe_req_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cbpe_rsp_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_wdata = '0;

   // Local copy of the path table and point count
   cbpe_vec_type pos_tab [PATH_DEPTH];
   cbpe_vec_type in_tab  [PATH_DEPTH];
   cbpe_vec_type out_tab [PATH_DEPTH];
   logic [6:0]   path_count = '0;

   cbpe_rsp_type curve_queue [$];
   stim_row_type stim_rows [$];

   int fail_count   = 0;
   int results_seen = 0;
   int write_items  = 0;
   int eval_items   = 0;
   int other_items  = 0;
   int count_loads  = 0;
   int drain_pauses = 0;
   int calm_left    = 0;

   cubic_bezier_path_evaluator_top #(
      .MAX_POINTS(PATH_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Signed 16.16 product, shifted down by the fraction width, wrapped to 32 bits
   function automatic logic [31:0] q16_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] prod;
      prod = $signed(a) * $signed(b);
      return prod[FRAC_BITS+31:FRAC_BITS];
   endfunction

   function automatic int live_points();
      return (path_count > PATH_DEPTH) ? PATH_DEPTH : int'(path_count);
   endfunction

   // Evaluate segment seg at t; returns 0 on an empty path
   function automatic bit curve_segment(input int seg, input logic [31:0] t,
                                        output cbpe_vec_type pt);
      int          live;
      int          k;
      logic [31:0] u, u2, u3, t2, t3;
      logic [31:0] p0, p1, p2, p3;
      logic [31:0] sum [2];
      live = live_points();
      pt = '0;
      if (live == 0) return 1'b0;
      // clamp to the last or first position
      if (seg >= live - 1) begin
         pt = pos_tab[live-1];
         return 1'b1;
      end
      if (seg < 0) begin
         pt = pos_tab[0];
         return 1'b1;
      end
      u  = ONE_FIXED - t;
      u2 = q16_mul(u, u);
      u3 = q16_mul(u2, u);
      t2 = q16_mul(t, t);
      t3 = q16_mul(t2, t);
      for (k = 0; k < 2; k++) begin
         p0 = (k == 0) ? pos_tab[seg].x : pos_tab[seg].y;
         p1 = p0 + ((k == 0) ? out_tab[seg].x : out_tab[seg].y);
         p3 = (k == 0) ? pos_tab[seg+1].x : pos_tab[seg+1].y;
         p2 = p3 + ((k == 0) ? in_tab[seg+1].x : in_tab[seg+1].y);
         sum[k] = q16_mul(p0, u3)
                + q16_mul(q16_mul(q16_mul(p1, u2), t), THREE_Q16)
                + q16_mul(q16_mul(q16_mul(p2, u), t2), THREE_Q16)
                + q16_mul(p3, t3);
      end
      pt.x = sum[0];
      pt.y = sum[1];
      return 1'b1;
   endfunction

   // Apply one accepted item to the local table; returns 1 when a result is due
   function automatic bit path_step(input cbpe_req_type it, output cbpe_rsp_type rsp);
      int           idx;
      longint       f;
      longint       lim;
      cbpe_vec_type pt;
      bit           ok;
      idx = $signed(it.point_index);
      rsp = '0;
      pt  = '0;
      ok  = 1'b0;
      case (it.cmd)
         CMD_WRITE: begin
            if (idx >= 0 && idx < PATH_DEPTH) begin
               pos_tab[idx].x = it.pos_x;
               pos_tab[idx].y = it.pos_y;
               in_tab[idx].x  = it.in_x;
               in_tab[idx].y  = it.in_y;
               out_tab[idx].x = it.out_x;
               out_tab[idx].y = it.out_y;
            end
            return 1'b0;
         end
         CMD_SEGMENT: ok = curve_segment(idx, it.param_t, pt);
         CMD_INDEX: begin
            // clamp the fractional index to 0 .. count, then split it
            f   = $signed(it.param_t);
            lim = longint'(live_points()) << FRAC_BITS;
            if (f < 0) f = 0;
            else if (f >= lim) f = lim;
            ok = curve_segment(int'(f >>> FRAC_BITS), 32'(f[FRAC_BITS-1:0]), pt);
         end
         default: return 1'b0;
      endcase
      rsp.curve_x     = pt.x;
      rsp.curve_y     = pt.y;
      rsp.empty_error = !ok;
      return 1'b1;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:          return 32'h7fff_ffff;
         1:          return 32'h8000_0000;
         2, 3, 4, 5: return $urandom();
         default:    return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_t();
      case ($urandom_range(0, 9))
         0:       return ONE_FIXED;
         1:       return $urandom();
         2:       return (($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000);
         default: return $urandom_range(0, ONE_FIXED);
      endcase
   endfunction

   function automatic cbpe_req_type random_write(input int idx);
      cbpe_req_type it;
      it.cmd         = CMD_WRITE;
      it.point_index = 8'(idx);
      it.param_t     = $urandom();
      it.pos_x       = rand_word();
      it.pos_y       = rand_word();
      it.in_x        = rand_word();
      it.in_y        = rand_word();
      it.out_x       = rand_word();
      it.out_y       = rand_word();
      return it;
   endfunction

   // Mostly in-range evaluations and writes, some noise
   function automatic cbpe_req_type random_item();
      cbpe_req_type it;
      int           live;
      int           pick;
      live = live_points();
      it   = random_write($urandom_range(0, PATH_DEPTH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if ($urandom_range(0, 9) == 0) it.point_index = 8'($urandom());
      end else if (pick < 65) begin
         it.cmd = CMD_SEGMENT;
         if (live >= 2 && $urandom_range(0, 9) != 0)
            it.point_index = 8'($urandom_range(0, live - 2));
         else
            it.point_index = 8'($urandom());
         it.param_t = random_t();
      end else if (pick < 92) begin
         it.cmd = CMD_INDEX;
         if ($urandom_range(0, 7) != 0)
            it.param_t = $urandom_range(0, (live << FRAC_BITS) + 256);
         else
            it.param_t = $urandom();
      end else begin
         it.cmd         = CMD_UNUSED;
         it.point_index = 8'($urandom());
      end
      return it;
   endfunction

   function automatic stim_row_type cfg_row(input logic [6:0] v);
      stim_row_type r;
      r           = '{default: '0};
      r.is_cfg    = 1'b1;
      r.cfg_value = v;
      return r;
   endfunction

   function automatic stim_row_type eval_row(input logic [1:0] cmd, input int idx,
                                             input logic [31:0] t);
      stim_row_type r;
      r                   = '{default: '0};
      r.req               = random_write(0);
      r.req.cmd           = cmd;
      r.req.point_index   = 8'(idx);
      r.req.param_t       = t;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [1:0] cmd, input int idx,
                                              input logic [31:0] t, input logic [31:0] x,
                                              input logic [31:0] y, input logic err);
      stim_row_type r;
      r                   = eval_row(cmd, idx, t);
      r.typed             = 1'b1;
      r.known.curve_x     = x;
      r.known.curve_y     = y;
      r.known.empty_error = err;
      return r;
   endfunction

   function automatic stim_row_type write_row(input int idx,
                                              input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] ix, input logic [31:0] iy,
                                              input logic [31:0] ox, input logic [31:0] oy);
      stim_row_type r;
      r           = '{default: '0};
      r.req       = random_write(idx);
      r.req.pos_x = px;
      r.req.pos_y = py;
      r.req.in_x  = ix;
      r.req.in_y  = iy;
      r.req.out_x = ox;
      r.req.out_y = oy;
      return r;
   endfunction

   // Append one row to the directed table
   function automatic void add_row(input stim_row_type r);
      stim_rows = {stim_rows, r};
   endfunction

   function automatic int idle_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (fail_count < 40)
         $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
      fail_count++;
   endtask

   // Drive one item, wait for acceptance, then record what it should produce
   task automatic send_item(input cbpe_req_type it, input bit typed,
                            input cbpe_rsp_type typed_rsp);
      int           gap;
      cbpe_rsp_type guess;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (path_step(it, guess)) begin
         curve_queue = {curve_queue, (typed ? typed_rsp : guess)};
         eval_items++;
      end else if (it.cmd == CMD_WRITE) begin
         write_items++;
      end else begin
         other_items++;
      end
   endtask

   // Hold the sender until every pending result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (curve_queue.size() != 0);
      drain_pauses++;
   endtask

   // Load point_count once the pipeline has gone quiet
   task automatic load_count(input logic [6:0] v);
      req_valid <= 1'b0;
      while (curve_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      path_count = v;
      count_loads++;
   endtask

   // Randomly stall the result side, with calm stretches
   initial begin : rsp_backpressure
      int r;
      wait (!reset);
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(30, 120)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            if (r < 85) repeat ($urandom_range(1, 3)) @(posedge clock);
            else if (r < 97) repeat ($urandom_range(4, 12)) @(posedge clock);
            else repeat ($urandom_range(30, 60)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Compare each accepted result with the oldest pending one
   always @(posedge clock) begin : rsp_check
      cbpe_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (curve_queue.size() == 0) begin
            flag_mismatch("unexpected result x", rsp_item.curve_x, '0);
         end else begin
            want = curve_queue.pop_front();
            if (rsp_item.curve_x !== want.curve_x)
               flag_mismatch("curve_x", rsp_item.curve_x, want.curve_x);
            if (rsp_item.curve_y !== want.curve_y)
               flag_mismatch("curve_y", rsp_item.curve_y, want.curve_y);
            if (rsp_item.empty_error !== want.empty_error)
               flag_mismatch("empty_error", 32'(rsp_item.empty_error),
                             32'(want.empty_error));
         end
         results_seen++;
      end
   end

   initial begin : watchdog
      #4000000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin : stimulus
      int phase_counts [10];
      int i;
      int n;
      int c;

      phase_counts = '{64, 127, 3, 0, 65, -1, 1, 2, 64, -1};

      // Empty path right after reset
      add_row(known_row(CMD_SEGMENT, 0, 32'h0, 32'h0, 32'h0, 1'b1));
      add_row(known_row(CMD_INDEX, 0, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1));
      add_row(known_row(CMD_SEGMENT, -128, 32'h8000_0000, 32'h0, 32'h0, 1'b1));
      add_row(eval_row(CMD_UNUSED, 127, 32'hffff_ffff));
      // Out-of-range writes are dropped; points 0 and 1 are then written
      add_row(write_row(-128, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1));
      add_row(write_row(64, 32'h2, 32'h2, 32'h2, 32'h2, 32'h2, 32'h2));
      add_row(write_row(127, 32'h3, 32'h3, 32'h3, 32'h3, 32'h3, 32'h3));
      add_row(write_row(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      add_row(write_row(1, 32'h0001_0000, 32'hfffe_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h0, 32'h0));
      // Single point: everything lands on it
      add_row(cfg_row(7'd1));
      add_row(known_row(CMD_SEGMENT, 0, 32'h0000_8000,
                        32'h7fff_ffff, 32'h8000_0000, 1'b0));
      add_row(known_row(CMD_INDEX, 5, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 1'b0));
      // Two points: clamps at both ends and the curve in between
      add_row(cfg_row(7'd2));
      add_row(known_row(CMD_SEGMENT, -128, 32'h0000_8000,
                        32'h7fff_ffff, 32'h8000_0000, 1'b0));
      add_row(known_row(CMD_SEGMENT, 127, 32'h0000_8000,
                        32'h0001_0000, 32'hfffe_0000, 1'b0));
      add_row(known_row(CMD_SEGMENT, 1, 32'h0,
                        32'h0001_0000, 32'hfffe_0000, 1'b0));
      add_row(eval_row(CMD_SEGMENT, 0, 32'h0));
      add_row(eval_row(CMD_SEGMENT, 0, ONE_FIXED));
      add_row(eval_row(CMD_SEGMENT, 0, 32'h0000_8000));
      add_row(eval_row(CMD_SEGMENT, 0, 32'h7fff_ffff));
      add_row(eval_row(CMD_SEGMENT, 0, 32'h8000_0000));
      add_row(known_row(CMD_INDEX, 0, 32'h7fff_ffff,
                        32'h0001_0000, 32'hfffe_0000, 1'b0));
      add_row(known_row(CMD_INDEX, 0, 32'h0002_0000,
                        32'h0001_0000, 32'hfffe_0000, 1'b0));
      add_row(eval_row(CMD_INDEX, 0, 32'h0001_ffff));
      add_row(eval_row(CMD_INDEX, 0, 32'hffff_8000));
      add_row(eval_row(CMD_INDEX, 0, 32'h0000_8000));
      add_row(write_row(63, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                        32'hffff_ffff, 32'h8000_0000, 32'h0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows
      for (i = 0; i < stim_rows.size(); i++) begin
         if (stim_rows[i].is_cfg)
            load_count(stim_rows[i].cfg_value);
         else
            send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].known);
      end

      // Fill the whole table before any wider count is used
      for (i = 0; i < PATH_DEPTH; i++)
         send_item(random_write(i), 1'b0, '0);

      // Random phases over several point counts
      for (i = 0; i < 10; i++) begin
         c = (phase_counts[i] < 0) ? $urandom_range(2, PATH_DEPTH - 1) : phase_counts[i];
         load_count(7'(c));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ((i == 2 && n == 90) || $urandom_range(0, 199) == 0)
               drain_results();
            send_item(random_item(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (curve_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d writes, %0d evaluations, %0d unused commands", write_items,
               eval_items, other_items);
      $display("across %0d point_count loads and %0d full drains, %0d results checked",
               count_loads, drain_pauses, results_seen);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
